// ----- hw/rtl/psfa_pkg.sv -----
// Shared types and constants for the power-of-two segregated free-list allocator.
// Used by the front classifier, the item queue, the back executor and the top level.
// No dependencies.
package psfa_pkg;

  // Field widths of the request and response items.
  localparam int ADDR_W = 16;
  localparam int SIZE_W = 17;
  localparam int STAT_W = 2;

  // Heap size in 16-byte units and number of size classes.
  localparam int HEAP_UNITS  = 65536;
  localparam int NUM_CLASSES = 17;

  // The class index, and the class value before the range check.
  localparam int CLS_W      = $clog2(NUM_CLASSES);
  localparam int CLS_CALC_W = $clog2(SIZE_W + 1);

  // The heap-top sum needs one more bit than a size.
  localparam int SUM_W = SIZE_W + 1;

  // The next-link memory holds a valid bit over an address.
  localparam int LINK_W     = ADDR_W + 1;
  localparam int LINK_DEPTH = 1 << ADDR_W;

  // Depth of the queue between the front and the back.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Bus widths: fields packed from bit zero, padded to whole bytes.
  localparam int IN_DATA_W  = ((SIZE_W + ADDR_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ADDR_W + SIZE_W + STAT_W + 7) / 8) * 8;

  // Request kinds on the input tuser bit.
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Response status codes.
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_OOM  = 2'd1;
  localparam logic [STAT_W-1:0] ST_ZERO = 2'd2;

  // Operation decided by the front for the back to carry out.
  typedef enum logic [1:0] {
    OP_ALLOC     = 2'd0,
    OP_FREE      = 2'd1,
    OP_ERR_ZERO  = 2'd2,
    OP_ERR_RANGE = 2'd3
  } op_t;

  // One classified request as it travels through the queue.
  typedef struct packed {
    op_t               op;
    logic [CLS_W-1:0]  cls;
    logic [SIZE_W-1:0] gsize;
    logic [ADDR_W-1:0] addr;
  } item_t;

endpackage

// ----- hw/rtl/psfa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Stands alone; used for the next-link store of the allocator.
// Contents are undefined until written.
module psfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/psfa_front.sv -----
// Front of the allocator: takes requests and sorts them into operations.
// Rounds the size up to a power of two and checks zero and range errors.
// Depends on psfa_pkg.
module psfa_front (
  input  logic                              s_valid,
  output logic                              s_ready,
  input  logic                              req_type,
  input  logic [psfa_pkg::SIZE_W-1:0]       size_blocks,
  input  logic [psfa_pkg::ADDR_W-1:0]       block_addr,
  input  logic                              q_full,
  output logic                              q_push,
  output psfa_pkg::item_t                   q_item
);

  logic [psfa_pkg::SIZE_W-1:0]     size_m1;
  logic [psfa_pkg::CLS_CALC_W-1:0] cls_calc;
  logic                            size_zero;
  logic                            out_of_range;

  // Ceiling log2: one above the highest set bit of size minus one.
  always_comb begin
    size_m1  = size_blocks - psfa_pkg::SIZE_W'(1);
    cls_calc = '0;
    for (int i = 0; i < psfa_pkg::SIZE_W; i++) begin
      if (size_m1[i]) begin
        cls_calc = psfa_pkg::CLS_CALC_W'(i + 1);
      end
    end
  end

  assign size_zero    = (size_blocks == '0);
  assign out_of_range = (cls_calc >= psfa_pkg::CLS_CALC_W'(psfa_pkg::NUM_CLASSES));

  // Classify the request into the operation the back will perform.
  always_comb begin
    q_item.cls   = psfa_pkg::CLS_W'(cls_calc);
    q_item.gsize = psfa_pkg::SIZE_W'(1) << cls_calc;
    q_item.addr  = block_addr;
    if (size_zero) begin
      q_item.op = psfa_pkg::OP_ERR_ZERO;
    end else if (out_of_range) begin
      q_item.op = psfa_pkg::OP_ERR_RANGE;
    end else if (req_type == psfa_pkg::REQ_FREE) begin
      q_item.op = psfa_pkg::OP_FREE;
    end else begin
      q_item.op = psfa_pkg::OP_ALLOC;
    end
  end

  // A transaction is taken whenever the queue has room.
  assign s_ready = !q_full;
  assign q_push  = s_valid && !q_full;

endmodule

// ----- hw/rtl/psfa_queue.sv -----
// Short queue of classified requests between the front and the back.
// Depends on psfa_pkg for the item type and depth.
// Lets either side stall without holding up the other.
module psfa_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  psfa_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output psfa_pkg::item_t head_item
);

  psfa_pkg::item_t                  slots [psfa_pkg::QDEPTH];
  logic [psfa_pkg::QPTR_W-1:0]      wptr;
  logic [psfa_pkg::QPTR_W-1:0]      rptr;
  logic [psfa_pkg::QCNT_W-1:0]      count;

  assign full      = (count == psfa_pkg::QCNT_W'(psfa_pkg::QDEPTH));
  assign valid     = (count != '0);
  assign head_item = slots[rptr];

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == psfa_pkg::QPTR_W'(psfa_pkg::QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == psfa_pkg::QPTR_W'(psfa_pkg::QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Item storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end

endmodule

// ----- hw/rtl/psfa_back.sv -----
// Back of the allocator: carries out allocs and frees on the class lists.
// Holds the heap top, the list heads and the next-link RAM, and the output register.
// Depends on psfa_pkg and psfa_ram.
module psfa_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  input  psfa_pkg::item_t                     q_item,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [psfa_pkg::ADDR_W-1:0]         out_addr,
  output logic [psfa_pkg::SIZE_W-1:0]         out_blocks,
  output logic [psfa_pkg::STAT_W-1:0]         out_status
);

  typedef enum logic [1:0] {
    S_EXEC = 2'b01,
    S_POP  = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  logic [psfa_pkg::SIZE_W-1:0] heap_top;
  logic [psfa_pkg::SIZE_W-1:0] heap_top_next;
  logic [psfa_pkg::ADDR_W-1:0] class_head     [psfa_pkg::NUM_CLASSES];
  logic                        class_nonempty [psfa_pkg::NUM_CLASSES];

  logic [psfa_pkg::ADDR_W-1:0] head_sel;
  logic                        ne_sel;
  logic [psfa_pkg::SUM_W-1:0]  top_sum;
  logic                        out_free;

  logic                        head_upd;
  logic [psfa_pkg::ADDR_W-1:0] head_val;
  logic                        ne_val;

  logic                        rd_en;
  logic                        wr_en;
  logic [psfa_pkg::LINK_W-1:0] link_wdata;
  logic [psfa_pkg::LINK_W-1:0] link_rdata;

  logic [psfa_pkg::ADDR_W-1:0] res_addr;
  logic [psfa_pkg::SIZE_W-1:0] res_blocks;
  logic [psfa_pkg::STAT_W-1:0] res_status;

  // Next-link store: the link of a freed block holds the old list head.
  psfa_ram #(
    .WIDTH (psfa_pkg::LINK_W),
    .DEPTH (psfa_pkg::LINK_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (q_item.addr),
    .wdata (link_wdata),
    .re    (rd_en),
    .raddr (head_sel),
    .rdata (link_rdata)
  );

  assign head_sel   = class_head[q_item.cls];
  assign ne_sel     = class_nonempty[q_item.cls];
  assign top_sum    = {1'b0, heap_top} + {1'b0, q_item.gsize};
  assign out_free   = !out_valid || out_ready;
  assign link_wdata = {ne_sel, head_sel};

  // Sequencer: a pop reads the link in S_EXEC and finishes in S_POP once the output register is free.
  always_comb begin
    state_next    = state;
    heap_top_next = heap_top;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    head_upd      = 1'b0;
    head_val      = q_item.addr;
    ne_val        = 1'b1;
    res_addr      = '0;
    res_blocks    = '0;
    res_status    = psfa_pkg::ST_OK;
    case (state)
      S_EXEC: begin
        if (q_valid) begin
          case (q_item.op)
            psfa_pkg::OP_ALLOC: begin
              if (ne_sel) begin
                rd_en      = 1'b1;
                state_next = S_POP;
              end else if (out_free) begin
                q_pop = 1'b1;
                if (top_sum > psfa_pkg::SUM_W'(psfa_pkg::HEAP_UNITS)) begin
                  res_status = psfa_pkg::ST_OOM;
                end else begin
                  res_addr      = heap_top[psfa_pkg::ADDR_W-1:0];
                  res_blocks    = q_item.gsize;
                  heap_top_next = top_sum[psfa_pkg::SIZE_W-1:0];
                end
              end
            end
            psfa_pkg::OP_FREE: begin
              if (out_free) begin
                q_pop    = 1'b1;
                wr_en    = 1'b1;
                head_upd = 1'b1;
              end
            end
            psfa_pkg::OP_ERR_ZERO: begin
              if (out_free) begin
                q_pop      = 1'b1;
                res_status = psfa_pkg::ST_ZERO;
              end
            end
            default: begin
              if (out_free) begin
                q_pop      = 1'b1;
                res_status = psfa_pkg::ST_OOM;
              end
            end
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          q_pop      = 1'b1;
          res_addr   = head_sel;
          res_blocks = q_item.gsize;
          head_upd   = 1'b1;
          head_val   = link_rdata[psfa_pkg::ADDR_W-1:0];
          ne_val     = link_rdata[psfa_pkg::ADDR_W];
          state_next = S_EXEC;
        end
      end
      default: begin
        state_next = S_EXEC;
      end
    endcase
  end

  // Control state: sequencer, heap top and list-empty flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_EXEC;
      heap_top <= '0;
      for (int i = 0; i < psfa_pkg::NUM_CLASSES; i++) begin
        class_nonempty[i] <= 1'b0;
        class_head[i]     <= '0;
      end
    end else begin
      state    <= state_next;
      heap_top <= heap_top_next;
      if (head_upd) begin
        class_head[q_item.cls]     <= head_val;
        class_nonempty[q_item.cls] <= ne_val;
      end
    end
  end

  // Output register: loads a result as the item leaves the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_addr   <= res_addr;
      out_blocks <= res_blocks;
      out_status <= res_status;
    end
  end

endmodule

// ----- hw/rtl/pow2_segregated_free_list_allocator.sv -----
// Top level of the power-of-two segregated free-list allocator.
// Joins the front classifier, the request queue and the back executor.
// Depends on psfa_pkg, psfa_front, psfa_queue and psfa_back.
//
//   Channel   Direction  tdata (low bit up)                           tuser
//   s_axis    in         size_blocks[16:0], block_addr[32:17]          req_type
//   m_axis    out        grant_addr[15:0], grant_blocks[32:16],        none
//                        status[34:33]
//
// A request passes the combinational front into the queue and then the back;
// an allocation that pops a class list goes from S_EXEC to S_POP, as its
// next-link read is registered before the head moves. Reset is synchronous and
// clears the heap top and every list; the link RAM needs no clearing.
// The queue holds two requests, so up to two more input transactions are taken
// while a result waits in the output register for m_axis_tready; after that
// s_axis_tready stays low until the result leaves.
module pow2_segregated_free_list_allocator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // size_blocks, block_addr, zero padding
  input  logic [psfa_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // req_type
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // grant_addr, grant_blocks, status, zero padding
  output logic [psfa_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  localparam int SIZE_LO = 0;
  localparam int ADDR_LO = psfa_pkg::SIZE_W;
  localparam int OUT_PAD = psfa_pkg::OUT_DATA_W - psfa_pkg::ADDR_W - psfa_pkg::SIZE_W
                           - psfa_pkg::STAT_W;

  logic                        q_push;
  logic                        q_full;
  logic                        q_pop;
  logic                        q_valid;
  psfa_pkg::item_t             q_in_item;
  psfa_pkg::item_t             q_item;
  logic [psfa_pkg::ADDR_W-1:0] grant_addr;
  logic [psfa_pkg::SIZE_W-1:0] grant_blocks;
  logic [psfa_pkg::STAT_W-1:0] status;

  // Request classification.
  psfa_front u_front (
    .s_valid     (s_axis_tvalid),
    .s_ready     (s_axis_tready),
    .req_type    (s_axis_tuser),
    .size_blocks (s_axis_tdata[SIZE_LO +: psfa_pkg::SIZE_W]),
    .block_addr  (s_axis_tdata[ADDR_LO +: psfa_pkg::ADDR_W]),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (q_in_item)
  );

  // Decoupling queue.
  psfa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head_item (q_item)
  );

  // List and heap operations.
  psfa_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_addr   (grant_addr),
    .out_blocks (grant_blocks),
    .out_status (status)
  );

  assign m_axis_tdata = {{OUT_PAD{1'b0}}, status, grant_blocks, grant_addr};

`ifndef NO_ASSERTIONS
  // The back only retires an item that the queue actually holds.
  a_pop_has_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("back retired an item from an empty queue");

  // An accepted request is waiting in the queue on the next cycle.
  a_accept_queued: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> q_valid)
    else $error("accepted request missing from the queue");

  // A zero-size request leaves as a size-zero result with no grant.
  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    (q_pop && (q_item.op == psfa_pkg::OP_ERR_ZERO)) |=>
      (m_axis_tvalid && (status == psfa_pkg::ST_ZERO) && (grant_blocks == '0)))
    else $error("zero-size request produced a wrong result");

  // A pushed item cannot enter a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("push into a full queue");
`endif

endmodule
